>>> hdl/prrs_pkg.sv
// Package for the priority round-robin scheduler: operation codes, controller
// states and the command and status bundles between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package prrs_pkg;

    // Fixed field widths of one request and one response beat.
    localparam int ID_W   = 6;
    localparam int PRIO_W = 3;
    localparam int KIND_W = 2;

    typedef logic [ID_W-1:0] t_id;

    // Operation carried by a request beat.
    typedef enum logic [KIND_W-1:0] {
        KIND_ADD     = 2'd0,
        KIND_FORCE   = 2'd1,
        KIND_GET     = 2'd2,
        KIND_UNREADY = 2'd3
    } t_kind;

    // Controller states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_FIND,
        ST_POP,
        ST_PROBE,
        ST_CHECK,
        ST_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic cap;    // capture the request beat
        logic clr;    // write one ready-flag entry of the clearing pass
        logic exec;   // carry out add, force, mark-not-ready or a forced grant
        logic find;   // latch the highest non-empty level
        logic pop;    // read the head entry of that level and pop it
        logic probe;  // latch the popped handle and read its ready flag
        logic check;  // grant the popped handle if it is still ready
        logic emit;   // load the response register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_done;     // last entry of the clearing pass is being written
        logic is_get;       // the captured request is a get-next
        logic forced_pend;  // a forced grant is pending
        logic map_empty;    // no level holds an entry
        logic hit;          // the popped handle is ready
        logic can_emit;     // the response register is free this cycle
    } t_sts;

endpackage

>>> hdl/prrs_if.sv
// Valid/ready channel interfaces for the request and response beats of the
// scheduler. Depends on prrs_pkg.
`timescale 1ns / 1ps

// Request channel: operation, process handle and priority level.
interface prrs_in_if import prrs_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    t_id                 process_id;
    logic [PRIO_W-1:0]   priority_req;

    modport source (output valid, kind, process_id, priority_req, input ready);
    modport sink   (input valid, kind, process_id, priority_req, output ready);
endinterface

// Response channel: success flag and grant.
interface prrs_out_if import prrs_pkg::*; ();
    logic valid;
    logic ready;
    logic accepted;
    logic grant_valid;
    t_id  grant_id;

    modport source (output valid, accepted, grant_valid, grant_id, input ready);
    modport sink   (input valid, accepted, grant_valid, grant_id, output ready);
endinterface

>>> hdl/prrs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module prrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/prrs_ctrl.sv
// Controller state machine of the scheduler: sequences the clearing pass,
// each operation and the ring pops of a get-next. Depends on prrs_pkg.
`timescale 1ns / 1ps

module prrs_ctrl import prrs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (i_sts.clr_done) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                if (i_sts.is_get && !i_sts.forced_pend) n_state = ST_FIND;
                else n_state = ST_DONE;
            end
            ST_FIND: begin
                if (i_sts.map_empty) n_state = ST_DONE;
                else n_state = ST_POP;
            end
            ST_POP: begin
                n_state = ST_PROBE;
            end
            ST_PROBE: begin
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                // A stale entry sends the search back to the level search.
                if (i_sts.hit) n_state = ST_DONE;
                else n_state = ST_FIND;
            end
            ST_DONE: begin
                if (i_sts.can_emit) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // Outputs.
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_CLEAR: o_cmd.clr = 1'b1;
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.cap  = i_in_valid;
            end
            ST_EXEC:  o_cmd.exec  = 1'b1;
            ST_FIND:  o_cmd.find  = 1'b1;
            ST_POP:   o_cmd.pop   = 1'b1;
            ST_PROBE: o_cmd.probe = 1'b1;
            ST_CHECK: o_cmd.check = 1'b1;
            ST_DONE:  o_cmd.emit  = i_sts.can_emit;
            default: begin
                o_cmd      = '0;
                o_in_ready = 1'b0;
            end
        endcase
    end

`ifndef SYNTH
    // Reset always restarts the clearing pass.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> r_state == ST_CLEAR)
        else $error("controller did not enter the clearing pass after reset");

    // An accepted beat is executed in the following cycle.
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_state == ST_EXEC)
        else $error("accepted beat was not executed");
`endif

endmodule

>>> hdl/prrs_dp.sv
// Datapath of the scheduler: per-level ring pointers and counts, the
// non-empty bitmap, the forced grant, the ring and ready-flag memories and
// the response register. Depends on prrs_pkg, prrs_if and prrs_ram.
`timescale 1ns / 1ps

module prrs_dp import prrs_pkg::*; #(
    parameter int LEVELS     = 8,
    parameter int RING_DEPTH = 8,
    parameter int PROCESSES  = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    input  logic [KIND_W-1:0] i_kind,
    input  t_id               i_process_id,
    input  logic [PRIO_W-1:0] i_priority_req,
    prrs_out_if.source        o_rsp
);

    localparam int LW  = $clog2(LEVELS);
    localparam int HW  = $clog2(RING_DEPTH);
    localparam int CW  = $clog2(RING_DEPTH + 1);
    localparam int RAW = $clog2(LEVELS * RING_DEPTH);
    localparam int PW  = $clog2(PROCESSES);
    localparam logic [RAW-1:0] DEPTH_R = RAW'(RING_DEPTH);

    // Captured request.
    t_kind             r_kind;
    t_id               r_pid;
    logic [PRIO_W-1:0] r_prio;

    // Scheduler state.
    logic [HW-1:0]     r_head  [LEVELS];
    logic [HW-1:0]     r_tail  [LEVELS];
    logic [CW-1:0]     r_count [LEVELS];
    logic [LEVELS-1:0] r_map;
    logic              r_fvalid;
    t_id               r_fid;
    logic [PW-1:0]     r_clr_addr;

    // Search and result registers.
    logic [LW-1:0]     r_lvl;
    t_id               r_id;
    logic              r_id_ok;
    logic              r_acc;
    logic              r_gv;
    t_id               r_gid;
    logic              r_out_valid;
    logic              r_out_acc;
    logic              r_out_gv;
    t_id               r_out_gid;

    logic              pid_ok;
    logic              lvl_ok;
    logic              fid_ok;
    logic              rd_ok;
    logic [LW-1:0]     add_lvl;
    logic              add_room;
    logic              add_ok;
    logic [LW-1:0]     top_lvl;
    logic              can_emit;
    logic              hit;

    logic              ring_we;
    logic [RAW-1:0]    ring_waddr;
    logic [RAW-1:0]    ring_raddr;
    t_id               ring_rdata;

    logic              rdy_we;
    logic [PW-1:0]     rdy_waddr;
    logic [0:0]        rdy_wdata;
    logic [PW-1:0]     rdy_raddr;
    logic [0:0]        rdy_rdata;

    function automatic logic [HW-1:0] ring_adv(input logic [HW-1:0] pos);
        if (pos == HW'(RING_DEPTH - 1)) ring_adv = '0;
        else ring_adv = pos + 1'b1;
    endfunction

    // Range checks and the add decision.
    assign pid_ok   = 32'(r_pid) < PROCESSES;
    assign lvl_ok   = 32'(r_prio) < LEVELS;
    assign fid_ok   = 32'(r_fid) < PROCESSES;
    assign rd_ok    = 32'(ring_rdata) < PROCESSES;
    assign add_lvl  = LW'(r_prio);
    assign add_room = r_count[add_lvl] < CW'(RING_DEPTH);
    assign add_ok   = (r_kind == KIND_ADD) && pid_ok && lvl_ok && add_room;
    assign hit      = r_id_ok && rdy_rdata[0];
    assign can_emit = !r_out_valid || o_rsp.ready;

    // Highest set bit of the non-empty bitmap.
    always_comb begin
        top_lvl = '0;
        for (int i = 0; i < LEVELS; i++) begin
            if (r_map[i]) top_lvl = LW'(i);
        end
    end

    // Ring store: appended at the tail of the add level, read at the head
    // of the level being searched.
    assign ring_we    = i_cmd.exec && add_ok;
    assign ring_waddr = RAW'(add_lvl) * DEPTH_R + RAW'(r_tail[add_lvl]);
    assign ring_raddr = RAW'(r_lvl) * DEPTH_R + RAW'(r_head[r_lvl]);

    prrs_ram #(
        .WIDTH (ID_W),
        .DEPTH (LEVELS * RING_DEPTH)
    ) u_ring_ram (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (ring_waddr),
        .i_wdata (r_pid),
        .i_re    (i_cmd.pop),
        .i_raddr (ring_raddr),
        .o_rdata (ring_rdata)
    );

    // Ready-flag writes: clearing pass, request operations and grants.
    always_comb begin
        rdy_we    = 1'b0;
        rdy_waddr = r_clr_addr;
        rdy_wdata = 1'b0;
        if (i_cmd.clr) begin
            rdy_we = 1'b1;
        end else if (i_cmd.exec) begin
            case (r_kind)
                KIND_ADD, KIND_FORCE: begin
                    rdy_we    = pid_ok;
                    rdy_waddr = PW'(r_pid);
                    rdy_wdata = 1'b1;
                end
                KIND_UNREADY: begin
                    rdy_we    = pid_ok;
                    rdy_waddr = PW'(r_pid);
                end
                KIND_GET: begin
                    rdy_we    = r_fvalid && fid_ok;
                    rdy_waddr = PW'(r_fid);
                end
                default: begin
                    rdy_we = 1'b0;
                end
            endcase
        end else if (i_cmd.check) begin
            rdy_we    = hit;
            rdy_waddr = PW'(r_id);
        end
    end

    assign rdy_raddr = PW'(ring_rdata);

    prrs_ram #(
        .WIDTH (1),
        .DEPTH (PROCESSES)
    ) u_ready_ram (
        .i_clk   (i_clk),
        .i_we    (rdy_we),
        .i_waddr (rdy_waddr),
        .i_wdata (rdy_wdata),
        .i_re    (i_cmd.probe && rd_ok),
        .i_raddr (rdy_raddr),
        .o_rdata (rdy_rdata)
    );

    // Ring pointers, bitmap, forced grant, clearing counter and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LEVELS; i++) begin
                r_head[i]  <= '0;
                r_tail[i]  <= '0;
                r_count[i] <= '0;
            end
            r_map       <= '0;
            r_fvalid    <= 1'b0;
            r_fid       <= '0;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (ring_we) begin
                r_tail[add_lvl]  <= ring_adv(r_tail[add_lvl]);
                r_count[add_lvl] <= r_count[add_lvl] + 1'b1;
                r_map[add_lvl]   <= 1'b1;
            end
            if (i_cmd.exec && r_kind == KIND_FORCE && pid_ok) begin
                r_fvalid <= 1'b1;
                r_fid    <= r_pid;
            end
            if (i_cmd.exec && r_kind == KIND_GET) begin
                r_fvalid <= 1'b0;
            end
            // A pop always consumes the head entry, stale or not.
            if (i_cmd.pop) begin
                r_head[r_lvl]  <= ring_adv(r_head[r_lvl]);
                r_count[r_lvl] <= r_count[r_lvl] - 1'b1;
                if (r_count[r_lvl] == CW'(1)) r_map[r_lvl] <= 1'b0;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request capture, search state and result values.
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_kind <= t_kind'(i_kind);
            r_pid  <= i_process_id;
            r_prio <= i_priority_req;
            r_acc  <= 1'b0;
            r_gv   <= 1'b0;
            r_gid  <= '0;
        end
        if (i_cmd.exec) begin
            case (r_kind)
                KIND_ADD:     r_acc <= add_ok;
                KIND_FORCE:   r_acc <= pid_ok;
                KIND_UNREADY: r_acc <= pid_ok;
                KIND_GET: begin
                    if (r_fvalid) begin
                        r_acc <= 1'b1;
                        r_gv  <= 1'b1;
                        r_gid <= r_fid;
                    end
                end
                default: r_acc <= 1'b0;
            endcase
        end
        if (i_cmd.find) begin
            r_lvl <= top_lvl;
        end
        if (i_cmd.probe) begin
            r_id    <= ring_rdata;
            r_id_ok <= rd_ok;
        end
        if (i_cmd.check && hit) begin
            r_acc <= 1'b1;
            r_gv  <= 1'b1;
            r_gid <= r_id;
        end
        if (i_cmd.emit) begin
            r_out_acc <= r_acc;
            r_out_gv  <= r_gv;
            r_out_gid <= r_gid;
        end
    end

    // Status to the controller.
    always_comb begin
        o_sts.clr_done    = i_cmd.clr && (r_clr_addr == PW'(PROCESSES - 1));
        o_sts.is_get      = r_kind == KIND_GET;
        o_sts.forced_pend = r_fvalid;
        o_sts.map_empty   = r_map == '0;
        o_sts.hit         = hit;
        o_sts.can_emit    = can_emit;
    end

    // Response channel.
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.accepted    = r_out_acc;
    assign o_rsp.grant_valid = r_out_gv;
    assign o_rsp.grant_id    = r_out_gid;

`ifndef SYNTH
    // A pop only ever targets a level that holds entries.
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |-> r_map[r_lvl] && (r_count[r_lvl] != '0))
        else $error("pop from an empty level");

    // A delivered grant is always reported as accepted.
    a_grant_accepted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_gv) |-> r_out_acc)
        else $error("grant without accepted flag");
`endif

endmodule

>>> hdl/priority_round_robin_scheduler_unit.sv
// Top level of the priority round-robin scheduler: joins the controller,
// the datapath and the channel interfaces. Depends on prrs_pkg, prrs_if,
// prrs_ctrl and prrs_dp.
//
// Usage:
//   i_req carries one operation per beat: add a process to its level's ring,
//   force it as the next grant, get the next grant, or mark it not ready.
//   o_rsp returns exactly one beat per request with the accepted flag and,
//   for a get-next, the granted process handle.
//   Add, force, mark-not-ready and a forced get-next run the execute step
//   and then load the response. Any other get-next adds a level search, ring
//   read, ready-flag read and check per popped entry, repeating them for every
//   stale entry it skips and ending after a level search that finds no entry.
//   One request is in flight at a time; the next can be taken in the cycle
//   after the response register is loaded.
//   After reset the ready-flag memory is swept to zero, one entry a cycle,
//   over all PROCESSES entries; no request is accepted during the sweep.
//   When the receiver stalls, the response is held in its register and the
//   next request may already be accepted; its result waits until the
//   register is free.
`timescale 1ns / 1ps

module priority_round_robin_scheduler_unit import prrs_pkg::*; #(
    parameter int LEVELS     = 8,
    parameter int RING_DEPTH = 8,
    parameter int PROCESSES  = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    prrs_in_if.sink     i_req,
    prrs_out_if.source  o_rsp
);

    t_cmd cmd;
    t_sts sts;
    logic in_ready;

    assign i_req.ready = in_ready;

    // Operation sequencing.
    prrs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Scheduler state and memories.
    prrs_dp #(
        .LEVELS     (LEVELS),
        .RING_DEPTH (RING_DEPTH),
        .PROCESSES  (PROCESSES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_kind         (i_req.kind),
        .i_process_id   (i_req.process_id),
        .i_priority_req (i_req.priority_req),
        .o_rsp          (o_rsp)
    );

endmodule

>>> test/tb_priority_round_robin_scheduler_unit.sv
// Self-checking testbench for the priority round-robin scheduler: drives request beats,
// tracks the scheduler state alongside the block and compares every response beat.
// Depends on prrs_pkg, prrs_if and priority_round_robin_scheduler_unit.
`timescale 1ns / 1ps

module tb_priority_round_robin_scheduler_unit;
    import prrs_pkg::*;

    localparam int NUM_LEVELS   = 8;
    localparam int RING_SLOTS   = 8;
    localparam int NUM_PROCS    = 64;
    localparam int HALF_PERIOD  = 6;
    localparam int QUIET_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 24;
    localparam int MAX_REPORTS  = 100;

    typedef logic [PRIO_W-1:0] t_prio;

    // One response beat as the scheduler should return it.
    typedef struct packed {
        logic accepted;
        logic grant_valid;
        t_id  grant_id;
    } t_sched_rsp;

    logic i_clk = 1'b0;
    logic i_rst_n;

    prrs_in_if  req_if ();
    prrs_out_if rsp_if ();

    priority_round_robin_scheduler_unit #(
        .LEVELS     (NUM_LEVELS),
        .RING_DEPTH (RING_SLOTS),
        .PROCESSES  (NUM_PROCS)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // Shadow copy of the scheduler state, updated as request beats are taken.
    t_id                   ring_ids  [NUM_LEVELS][RING_SLOTS];
    int                    ring_rd   [NUM_LEVELS] = '{default: 0};
    int                    ring_wr   [NUM_LEVELS] = '{default: 0};
    int                    ring_fill [NUM_LEVELS] = '{default: 0};
    logic [NUM_LEVELS-1:0] level_busy = '0;
    logic [NUM_PROCS-1:0]  proc_ready = '0;
    logic                  force_pend = 1'b0;
    t_id                   force_pid  = '0;

    // Responses owed by the block, oldest first.
    t_sched_rsp due_rsp_q[$];

    // Run statistics and error tally.
    int n_errors    = 0;
    int n_requests  = 0;
    int n_responses = 0;
    int n_grants    = 0;
    int n_forced    = 0;
    int n_stale     = 0;
    int n_refused   = 0;

    // Traffic shaping shared by the sender and the receiver.
    bit steady    = 1'b0;
    int hold_left = 0;
    int quiet_cycles = 0;

    // Clock generation.
    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    // Idle length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (steady) return 0;
        if (roll < 50) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Apply one operation to the shadow state and return the response it earns.
    function automatic t_sched_rsp sched_step(t_kind kind, t_id pid, t_prio prio);
        t_sched_rsp rsp;
        int lvl;
        int top;
        t_id head_pid;
        rsp = '0;
        // Every 3-bit level and 6-bit handle is in range for this configuration.
        lvl = int'(prio);
        case (kind)
            KIND_ADD: begin
                proc_ready[pid] = 1'b1;
                if (ring_fill[lvl] < RING_SLOTS) begin
                    ring_ids[lvl][ring_wr[lvl]] = pid;
                    ring_wr[lvl] = (ring_wr[lvl] + 1) % RING_SLOTS;
                    ring_fill[lvl]++;
                    level_busy[lvl] = 1'b1;
                    rsp.accepted = 1'b1;
                end else begin
                    // A full ring refuses the entry but the process stays ready.
                    n_refused++;
                end
            end
            KIND_FORCE: begin
                // A later force simply replaces an earlier one.
                proc_ready[pid] = 1'b1;
                force_pend = 1'b1;
                force_pid = pid;
                rsp.accepted = 1'b1;
            end
            KIND_GET: begin
                if (force_pend) begin
                    // The forced process wins even if it was marked not ready since.
                    force_pend = 1'b0;
                    proc_ready[force_pid] = 1'b0;
                    rsp.grant_valid = 1'b1;
                    rsp.grant_id = force_pid;
                    n_forced++;
                end else begin
                    // Pop the highest busy level until a ready handle turns up.
                    while (level_busy != '0 && !rsp.grant_valid) begin
                        top = 0;
                        for (int l = 0; l < NUM_LEVELS; l++) begin
                            if (level_busy[l]) top = l;
                        end
                        head_pid = ring_ids[top][ring_rd[top]];
                        ring_rd[top] = (ring_rd[top] + 1) % RING_SLOTS;
                        ring_fill[top]--;
                        if (ring_fill[top] == 0) level_busy[top] = 1'b0;
                        if (proc_ready[head_pid]) begin
                            proc_ready[head_pid] = 1'b0;
                            rsp.grant_valid = 1'b1;
                            rsp.grant_id = head_pid;
                        end else begin
                            n_stale++;
                        end
                    end
                end
                rsp.accepted = rsp.grant_valid;
            end
            default: begin
                proc_ready[pid] = 1'b0;
                rsp.accepted = 1'b1;
            end
        endcase
        return rsp;
    endfunction

    // Count a mismatch and print it while the log is still short.
    task automatic report_error(string msg);
        n_errors++;
        if (n_errors <= MAX_REPORTS) $display("[%0t] ERROR: %s", $time, msg);
    endtask

    // Offer one request beat after a random gap and wait until it is taken.
    task automatic send_request(t_kind kind, t_id pid, t_prio prio);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_if.valid        <= 1'b1;
        req_if.kind         <= kind;
        req_if.process_id   <= pid;
        req_if.priority_req <= prio;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        due_rsp_q.push_back(sched_step(kind, pid, prio));
        n_requests++;
        @(negedge i_clk);
    endtask

    // Receiver: random stalls, plus a long hold whenever a test asks for one.
    initial begin : rsp_sink
        int stall_left;
        int n;
        stall_left = 0;
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                rsp_if.ready <= 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                rsp_if.ready <= 1'b0;
                stall_left--;
            end else begin
                n = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
                rsp_if.ready <= (n == 0);
                stall_left = (n > 0) ? n - 1 : 0;
            end
        end
    end

    // Compare each response beat with the oldest outstanding one.
    always @(posedge i_clk) begin : rsp_check
        t_sched_rsp want;
        if (i_rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            n_responses++;
            if (rsp_if.grant_valid === 1'b1) n_grants++;
            if (due_rsp_q.size() == 0) begin
                report_error($sformatf("response beat with nothing outstanding (id %0d)",
                                       rsp_if.grant_id));
            end else begin
                want = due_rsp_q.pop_front();
                if (rsp_if.accepted !== want.accepted)
                    report_error($sformatf("beat %0d accepted %b, want %b", n_responses,
                                           rsp_if.accepted, want.accepted));
                if (rsp_if.grant_valid !== want.grant_valid)
                    report_error($sformatf("beat %0d grant_valid %b, want %b", n_responses,
                                           rsp_if.grant_valid, want.grant_valid));
                if (rsp_if.grant_id !== want.grant_id)
                    report_error($sformatf("beat %0d grant_id %0d, want %0d", n_responses,
                                           rsp_if.grant_id, want.grant_id));
            end
        end
    end

    // Watchdog: too long without a beat on either channel ends the run.
    always @(posedge i_clk) begin
        if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
            (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[%0t] watchdog: no beat for %0d cycles", $time, QUIET_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    // A get with nothing queued, and mark-not-ready on an idle process.
    task automatic test_empty_scheduler();
        send_request(KIND_GET, 6'd0, 3'd0);
        send_request(KIND_UNREADY, 6'd63, 3'd7);
    endtask

    // One add more than a ring holds: the last one is refused.
    task automatic test_ring_full();
        for (int i = 1; i <= RING_SLOTS + 1; i++) send_request(KIND_ADD, t_id'(i), 3'd5);
    endtask

    // Priority order across levels and skipping of entries no longer ready.
    task automatic test_stale_entries();
        send_request(KIND_UNREADY, 6'd1, 3'd0);
        send_request(KIND_UNREADY, 6'd2, 3'd0);
        send_request(KIND_ADD, 6'd63, 3'd7);
        send_request(KIND_ADD, 6'd0, 3'd0);
        send_request(KIND_GET, 6'd0, 3'd0);
        send_request(KIND_GET, 6'd0, 3'd0);
    endtask

    // Forcing twice, a forced process marked not ready, and a forced handle
    // whose own ring entry is left queued.
    task automatic test_forced_grant();
        send_request(KIND_FORCE, 6'd40, 3'd0);
        send_request(KIND_FORCE, 6'd50, 3'd0);
        send_request(KIND_UNREADY, 6'd50, 3'd0);
        send_request(KIND_GET, 6'd0, 3'd0);
        send_request(KIND_GET, 6'd0, 3'd0);
        send_request(KIND_FORCE, 6'd5, 3'd0);
        send_request(KIND_GET, 6'd0, 3'd0);
        send_request(KIND_GET, 6'd0, 3'd0);
    endtask

    // Random operations with a given mix; mark-not-ready takes the rest.
    task automatic test_random_mix(int count, int pct_add, int pct_force, int pct_get,
                                   int pid_max, bit no_gaps);
        int roll;
        t_kind kind;
        steady = no_gaps;
        for (int i = 0; i < count; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < pct_add) kind = KIND_ADD;
            else if (roll < pct_add + pct_force) kind = KIND_FORCE;
            else if (roll < pct_add + pct_force + pct_get) kind = KIND_GET;
            else kind = KIND_UNREADY;
            send_request(kind, t_id'($urandom_range(0, pid_max)), t_prio'($urandom_range(0, 7)));
        end
        steady = 1'b0;
    endtask

    // The receiver holds off while requests keep coming, so the block backs up.
    task automatic test_backpressure();
        steady = 1'b1;
        hold_left = 300;
        for (int i = 0; i < 16; i++) begin
            send_request((i % 3 == 2) ? KIND_GET : KIND_ADD, t_id'($urandom_range(0, 63)),
                         t_prio'($urandom_range(0, 7)));
        end
        steady = 1'b0;
    endtask

    // Wait for all responses, let the block settle, then give the verdict.
    task automatic finish_run();
        req_if.valid <= 1'b0;
        while (due_rsp_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Covered %0d requests and %0d responses, %0d of them grants (%0d forced).",
                 n_requests, n_responses, n_grants, n_forced);
        $display("Skipped %0d stale ring entries; refused %0d adds on a full ring.",
                 n_stale, n_refused);
        if (n_errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    endtask

    // Test sequence.
    initial begin
        i_rst_n             = 1'b0;
        req_if.valid        = 1'b0;
        req_if.kind         = KIND_ADD;
        req_if.process_id   = '0;
        req_if.priority_req = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_scheduler();
        test_ring_full();
        test_stale_entries();
        test_forced_grant();

        test_random_mix(400, 35, 10, 35, 63, 1'b0);
        test_random_mix(300, 65, 5, 20, 63, 1'b0);
        test_backpressure();
        test_random_mix(300, 15, 5, 70, 63, 1'b0);
        test_random_mix(300, 40, 5, 25, 15, 1'b0);
        test_random_mix(400, 35, 10, 35, 63, 1'b1);

        finish_run();
    end

endmodule
